@@ rtl/rv32_pkg.sv @@
// Package for the RV32IM execute block: constants, state codes and controller/datapath structs
package rv32_pkg;

	localparam int RamBytes = 1024;
	localparam int RamAw = $clog2(RamBytes);
	localparam int RxDepth = 16;
	localparam int RxAw = $clog2(RxDepth);

	localparam logic [31:0] TX_ADDR = 32'h0100_0000;
	localparam logic [31:0] RX_ADDR = 32'h0100_0004;
	localparam logic [31:0] LED_ADDR = 32'h0100_0100;
	localparam logic [31:0] PC_RESET = 32'h8000_0000;
	localparam logic [31:0] RAM_BASE_RESET = 32'h8000_0000;

	localparam logic [6:0] OPC_LUI = 7'h37;
	localparam logic [6:0] OPC_AUIPC = 7'h17;
	localparam logic [6:0] OPC_JAL = 7'h6f;
	localparam logic [6:0] OPC_JALR = 7'h67;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LOAD = 7'h03;
	localparam logic [6:0] OPC_STORE = 7'h23;
	localparam logic [6:0] OPC_OPIMM = 7'h13;
	localparam logic [6:0] OPC_OP = 7'h33;
	localparam logic [6:0] OPC_FENCE = 7'h0f;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT = 7'h20;
	localparam logic [6:0] F7_MULDIV = 7'h01;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MUL_HI,
		ST_MUL_DONE,
		ST_DIV,
		ST_MEM_RD,
		ST_MEM_WAIT,
		ST_MEM_WR,
		ST_WRITEBACK,
		ST_RESULT
	} state_t;

	// Decode and progress status from datapath to controller
	typedef struct packed {
		logic is_push;
		logic valid_instr;
		logic is_load;
		logic is_store;
		logic is_mul;
		logic is_div;
		logic [2:0] nbytes_m1;
		logic bytes_last;
		logic div_last;
		logic ram_hit;
	} dp_status_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic take_in;
		logic decode;
		logic mul_hi;
		logic mul_done;
		logic div_start;
		logic div_step;
		logic mem_rd_issue;
		logic mem_rd_capture;
		logic mem_wr;
		logic writeback;
		logic out_load;
	} dp_cmd_t;

endpackage

@@ rtl/rv32im_instruction_execute.sv @@
// Top level of the RV32IM execute block: stream ports, controller, datapath, output register
// Multiplies use one 33x33 multiplier (registered), divides and remainders a 32-step radix-2
// divider, and loads and stores move one byte at a time through the byte-wide RAM port.
// The result sits in an output register while the next item is accepted; RAM content is
// undefined after reset, so read only bytes already written.
module rv32im_instruction_execute (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [31:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	input logic [39:0] s_tdata, // instr_word[31:0], rx_byte[39:32]
	input logic s_tuser, // op
	output logic m_tvalid,
	input logic m_tready,
	output logic [55:0] m_tdata, // pc_after, tx_valid, tx_data, led_value, rx_dropped, pad
	output logic m_tuser // executed
);

	rv32_pkg::dp_cmd_t cmd;
	rv32_pkg::dp_status_t st;
	logic busy, in_fire, out_free, mvalid_q;
	logic [31:0] r_pc;
	logic r_exec, r_txv, r_drop;
	logic [7:0] r_txd, r_led;
	logic [55:0] mdata_q;
	logic muser_q;

	assign cfg_ready = 1'b1;
	assign s_tready = !busy;
	assign in_fire = s_tvalid && s_tready;
	assign out_free = !mvalid_q || m_tready;

	rv32_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_free(out_free),
		.st(st), .cmd(cmd), .busy(busy)
	);

	rv32_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.cfg_we(cfg_valid), .cfg_data(cfg_data),
		.in_op(s_tuser), .in_word(s_tdata[31:0]), .in_rx(s_tdata[39:32]),
		.res_pc(r_pc), .res_exec(r_exec), .res_txv(r_txv), .res_txd(r_txd),
		.res_led(r_led), .res_drop(r_drop)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			mvalid_q <= 1'b1;
		end else if (m_tready) begin
			mvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mdata_q <= {5'd0, r_drop, r_led, r_txd, r_txv, r_pc};
			muser_q <= r_exec;
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata = mdata_q;
	assign m_tuser = muser_q;

endmodule

@@ rtl/rv32_ram.sv @@
// Generic single-port RAM with registered read
module rv32_ram #(
	parameter int Width = 8,
	parameter int Depth = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] addr,
	input logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ rtl/rv32_ctrl.sv @@
// Controller state machine sequencing decode, multiply, divide, byte memory and writeback
module rv32_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input logic out_free,
	input rv32_pkg::dp_status_t st,
	output rv32_pkg::dp_cmd_t cmd,
	output logic busy
);

	rv32_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rv32_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != rv32_pkg::ST_IDLE);
		case (state_q)
			rv32_pkg::ST_IDLE: begin
				if (in_fire) begin
					cmd.take_in = 1'b1;
					state_d = rv32_pkg::ST_DECODE;
				end
			end
			rv32_pkg::ST_DECODE: begin
				cmd.decode = 1'b1;
				if (st.is_push || !st.valid_instr) begin
					state_d = rv32_pkg::ST_RESULT;
				end else if (st.is_mul) begin
					state_d = rv32_pkg::ST_MUL_HI;
				end else if (st.is_div) begin
					cmd.div_start = 1'b1;
					state_d = rv32_pkg::ST_DIV;
				end else if (st.is_load) begin
					state_d = rv32_pkg::ST_MEM_RD;
				end else if (st.is_store) begin
					state_d = rv32_pkg::ST_MEM_WR;
				end else begin
					state_d = rv32_pkg::ST_WRITEBACK;
				end
			end
			rv32_pkg::ST_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d = rv32_pkg::ST_MUL_DONE;
			end
			rv32_pkg::ST_MUL_DONE: begin
				cmd.mul_done = 1'b1;
				state_d = rv32_pkg::ST_WRITEBACK;
			end
			rv32_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_d = rv32_pkg::ST_WRITEBACK;
				end
			end
			rv32_pkg::ST_MEM_RD: begin
				cmd.mem_rd_issue = 1'b1;
				state_d = rv32_pkg::ST_MEM_WAIT;
			end
			rv32_pkg::ST_MEM_WAIT: begin
				cmd.mem_rd_capture = 1'b1;
				if (st.bytes_last) begin
					state_d = rv32_pkg::ST_WRITEBACK;
				end else begin
					state_d = rv32_pkg::ST_MEM_RD;
				end
			end
			rv32_pkg::ST_MEM_WR: begin
				cmd.mem_wr = 1'b1;
				if (st.bytes_last) begin
					state_d = rv32_pkg::ST_RESULT;
				end
			end
			rv32_pkg::ST_WRITEBACK: begin
				cmd.writeback = 1'b1;
				state_d = rv32_pkg::ST_RESULT;
			end
			rv32_pkg::ST_RESULT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = rv32_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rv32_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/rv32_dpath.sv @@
// Datapath: register file, pc, ALU, shared multiplier, radix-2 divider, byte RAM and I/O
module rv32_dpath (
	input logic clk,
	input logic arst_n,
	input rv32_pkg::dp_cmd_t cmd,
	output rv32_pkg::dp_status_t st,
	input logic cfg_we,
	input logic [31:0] cfg_data,
	input logic in_op,
	input logic [31:0] in_word,
	input logic [7:0] in_rx,
	output logic [31:0] res_pc,
	output logic res_exec,
	output logic res_txv,
	output logic [7:0] res_txd,
	output logic [7:0] res_led,
	output logic res_drop
);

	// Item registers
	logic op_q;
	logic [31:0] w_q;
	logic [7:0] rxb_q;
	logic [31:0] ram_base_q, pc_q;
	logic [31:0] regs_q [32];
	logic [31:0] a_q, b_q, v_q, next_q;
	logic wr_q, exec_q, txv_q, drop_q;
	logic [7:0] tx_q, led_q;
	logic [RxAwL-1:0] head_q, tail_q;
	localparam int RxAwL = rv32_pkg::RxAw;

	logic [6:0] opc, f7;
	logic [2:0] f3;
	logic [4:0] rd;
	assign opc = w_q[6:0];
	assign rd = w_q[11:7];
	assign f3 = w_q[14:12];
	assign f7 = w_q[31:25];

	logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
	assign imm_i = {{20{w_q[31]}}, w_q[31:20]};
	assign imm_s = {{20{w_q[31]}}, w_q[31:25], w_q[11:7]};
	assign imm_b = {{19{w_q[31]}}, w_q[31], w_q[7], w_q[30:25], w_q[11:8], 1'b0};
	assign imm_j = {{11{w_q[31]}}, w_q[31], w_q[19:12], w_q[20], w_q[30:21], 1'b0};
	assign imm_u = {w_q[31:12], 12'h000};

	// Operand read (registered into a_q and b_q when the item is taken, for decode)
	logic [31:0] ra, rb;
	assign ra = regs_q[in_word[19:15]];
	assign rb = regs_q[in_word[24:20]];

	// Decode and combinational ALU
	logic valid, is_ld, is_stv, is_mul, is_div, wr_c;
	logic [31:0] v_c, next_c, opb, addsub, shl, shr;
	logic lt_s, lt_u, eq, take;
	logic [4:0] sh;
	always_comb begin
		opb = (opc == rv32_pkg::OPC_OP) ? b_q : imm_i;
		sh = opb[4:0];
		addsub = (opc == rv32_pkg::OPC_OP && f7 == rv32_pkg::F7_ALT) ? a_q - opb : a_q + opb;
		shl = a_q << sh;
		shr = (f7 == rv32_pkg::F7_ALT) ? 32'($signed(a_q) >>> sh) : a_q >> sh;
		lt_s = $signed(a_q) < $signed(opb);
		lt_u = a_q < opb;
		eq = a_q == b_q;
		valid = 1'b1;
		is_ld = 1'b0;
		is_stv = 1'b0;
		is_mul = 1'b0;
		is_div = 1'b0;
		wr_c = 1'b0;
		v_c = '0;
		next_c = pc_q + 32'd4;
		take = 1'b0;
		case (opc)
			rv32_pkg::OPC_LUI: begin
				v_c = imm_u;
				wr_c = 1'b1;
			end
			rv32_pkg::OPC_AUIPC: begin
				v_c = pc_q + imm_u;
				wr_c = 1'b1;
			end
			rv32_pkg::OPC_JAL: begin
				v_c = pc_q + 32'd4;
				wr_c = 1'b1;
				next_c = pc_q + imm_j;
			end
			rv32_pkg::OPC_JALR: begin
				valid = (f3 == 3'd0);
				v_c = pc_q + 32'd4;
				wr_c = 1'b1;
				next_c = (a_q + imm_i) & ~32'd1;
			end
			rv32_pkg::OPC_BRANCH: begin
				case (f3)
					3'd0: take = eq;
					3'd1: take = !eq;
					3'd4: take = $signed(a_q) < $signed(b_q);
					3'd5: take = !($signed(a_q) < $signed(b_q));
					3'd6: take = a_q < b_q;
					3'd7: take = !(a_q < b_q);
					default: valid = 1'b0;
				endcase
				if (take) begin
					next_c = pc_q + imm_b;
				end
			end
			rv32_pkg::OPC_LOAD: begin
				valid = (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd2 || f3 == 3'd4
					|| f3 == 3'd5);
				is_ld = 1'b1;
				wr_c = 1'b1;
			end
			rv32_pkg::OPC_STORE: begin
				valid = (f3 <= 3'd2);
				is_stv = 1'b1;
			end
			rv32_pkg::OPC_OPIMM, rv32_pkg::OPC_OP: begin
				wr_c = 1'b1;
				if (opc == rv32_pkg::OPC_OP && f7 == rv32_pkg::F7_MULDIV) begin
					is_mul = !f3[2];
					is_div = f3[2];
				end else if (opc == rv32_pkg::OPC_OP && f7 != rv32_pkg::F7_BASE
					&& !(f7 == rv32_pkg::F7_ALT && (f3 == 3'd0 || f3 == 3'd5))) begin
					valid = 1'b0;
				end
				case (f3)
					3'd0: v_c = addsub;
					3'd1: begin
						v_c = shl;
						if (opc == rv32_pkg::OPC_OPIMM && f7 != rv32_pkg::F7_BASE) begin
							valid = 1'b0;
						end
					end
					3'd2: v_c = {31'd0, lt_s};
					3'd3: v_c = {31'd0, lt_u};
					3'd4: v_c = a_q ^ opb;
					3'd5: begin
						v_c = shr;
						if (opc == rv32_pkg::OPC_OPIMM && f7 != rv32_pkg::F7_BASE
							&& f7 != rv32_pkg::F7_ALT) begin
							valid = 1'b0;
						end
					end
					3'd6: v_c = a_q | opb;
					3'd7: v_c = a_q & opb;
					default: v_c = '0;
				endcase
			end
			rv32_pkg::OPC_FENCE: valid = (f3 <= 3'd1);
			default: valid = 1'b0;
		endcase
	end

	// Multiplier: one registered 33x33 product, from which the low or high half is taken
	logic signed [32:0] ma, mb;
	logic signed [65:0] prod_q;
	always_comb begin
		ma = {(f3 == 3'd1 || f3 == 3'd2) & a_q[31], a_q};
		mb = {(f3 == 3'd1) & b_q[31], b_q};
	end
	always_ff @(posedge clk) begin
		if (cmd.mul_hi) begin
			prod_q <= ma * mb;
		end
	end

	// Radix-2 restoring divider on magnitudes, 32 steps
	logic [31:0] dq_q, dr_q, dd_q;
	logic [5:0] dcnt_q;
	logic dneg_q, rneg_q;
	logic [32:0] dtrial;
	logic [31:0] drem_sh;
	logic sgn_div;
	assign sgn_div = !f3[0];
	assign drem_sh = {dr_q[30:0], dq_q[31]};
	assign dtrial = {dr_q, dq_q[31]} - {1'b0, dd_q};
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dq_q <= (sgn_div && a_q[31]) ? -a_q : a_q;
			dd_q <= (sgn_div && b_q[31]) ? -b_q : b_q;
			dr_q <= '0;
			dcnt_q <= '0;
			dneg_q <= sgn_div && (a_q[31] ^ b_q[31]);
			rneg_q <= sgn_div && a_q[31];
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + 6'd1;
			if (!dtrial[32]) begin
				dr_q <= dtrial[31:0];
				dq_q <= {dq_q[30:0], 1'b1};
			end else begin
				dr_q <= drem_sh;
				dq_q <= {dq_q[30:0], 1'b0};
			end
		end
	end
	logic [31:0] div_res;
	always_comb begin
		if (b_q == '0) begin
			div_res = f3[1] ? a_q : 32'hffff_ffff;
		end else if (f3[1]) begin
			div_res = rneg_q ? -dr_q : dr_q;
		end else begin
			div_res = dneg_q ? -dq_q : dq_q;
		end
	end

	// Byte-serial memory access
	localparam int RamAwL = rv32_pkg::RamAw;
	logic [2:0] bidx_q, nb_m1;
	logic [31:0] baddr, boff;
	logic ram_hit, rx_hit, tx_hit, led_hit, ring_empty;
	logic [7:0] ram_rd, bbyte;
	logic [RamAwL-1:0] ram_a;
	logic ram_we, hit_q, rxpop_q;
	logic [7:0] rxb_rd_q;
	assign nb_m1 = (f3[1:0] == 2'd0) ? 3'd0 : (f3[1:0] == 2'd1) ? 3'd1 : 3'd3;
	assign baddr = a_q + (is_stv ? imm_s : imm_i) + {29'd0, bidx_q};
	assign boff = baddr - ram_base_q;
	assign ram_hit = (baddr >= ram_base_q) && (boff < 32'(rv32_pkg::RamBytes));
	assign rx_hit = baddr == rv32_pkg::RX_ADDR;
	assign tx_hit = baddr == rv32_pkg::TX_ADDR;
	assign led_hit = baddr == rv32_pkg::LED_ADDR;
	assign ring_empty = head_q == tail_q;
	assign ram_a = boff[RamAwL-1:0];
	assign ram_we = cmd.mem_wr && ram_hit;
	assign bbyte = b_q[8*bidx_q[1:0] +: 8];

	rv32_ram #(.Width(8), .Depth(rv32_pkg::RamBytes)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_a), .wdata(bbyte), .rdata(ram_rd)
	);

	// Receive ring storage
	logic [7:0] ring_q [rv32_pkg::RxDepth];
	always_ff @(posedge clk) begin
		if (cmd.decode && op_q && (RxAwL'(head_q + 1'b1) != tail_q)) begin
			ring_q[head_q] <= rxb_q;
		end
		if (cmd.mem_rd_issue) begin
			rxb_rd_q <= ring_q[tail_q];
		end
	end

	logic [7:0] got;
	assign got = hit_q ? ram_rd : (rxpop_q ? rxb_rd_q : 8'd0);

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			op_q <= in_op;
			w_q <= in_word;
			rxb_q <= in_rx;
			a_q <= ra;
			b_q <= rb;
		end
		if (cmd.decode) begin
			v_q <= v_c;
			next_q <= next_c;
			wr_q <= wr_c && valid;
			bidx_q <= '0;
		end
		if (cmd.mem_rd_issue) begin
			hit_q <= ram_hit;
			rxpop_q <= rx_hit && !ram_hit && !ring_empty;
		end
		if (cmd.mem_rd_capture) begin
			v_q[8*bidx_q[1:0] +: 8] <= got;
			bidx_q <= bidx_q + 3'd1;
		end
		if (cmd.mem_wr) begin
			bidx_q <= bidx_q + 3'd1;
		end
		if (cmd.mem_rd_capture && bidx_q == nb_m1) begin
			if (f3 == 3'd0) v_q[31:8] <= {24{got[7]}};
			else if (f3 == 3'd4) v_q[31:8] <= '0;
			else if (f3 == 3'd1) v_q[31:16] <= {16{got[7]}};
			else if (f3 == 3'd5) v_q[31:16] <= '0;
		end
		if (cmd.mul_done) begin
			v_q <= (f3 == 3'd0) ? prod_q[31:0] : prod_q[63:32];
		end
		if (cmd.div_step && dcnt_q == 6'd31) begin
			v_q <= '0;
		end
	end

	// Control state of the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 32; i++) begin
				regs_q[i] <= '0;
			end
			pc_q <= rv32_pkg::PC_RESET;
			ram_base_q <= rv32_pkg::RAM_BASE_RESET;
			head_q <= '0;
			tail_q <= '0;
			tx_q <= '0;
			led_q <= '0;
			exec_q <= 1'b0;
			txv_q <= 1'b0;
			drop_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ram_base_q <= cfg_data;
			end
			if (cmd.decode) begin
				exec_q <= !op_q && valid;
				txv_q <= 1'b0;
				drop_q <= 1'b0;
				if (op_q) begin
					if (RxAwL'(head_q + 1'b1) == tail_q) begin
						drop_q <= 1'b1;
					end else begin
						head_q <= RxAwL'(head_q + 1'b1);
					end
				end else if (valid) begin
					pc_q <= next_c;
				end
			end
			if (cmd.mem_rd_capture && rxpop_q) begin
				tail_q <= RxAwL'(tail_q + 1'b1);
			end
			if (cmd.mem_wr && !ram_hit) begin
				if (tx_hit) begin
					tx_q <= bbyte;
					txv_q <= 1'b1;
				end else if (led_hit) begin
					led_q <= bbyte;
				end
			end
			if (cmd.writeback && wr_q && rd != 5'd0) begin
				regs_q[rd] <= (opc == rv32_pkg::OPC_OP && f7 == rv32_pkg::F7_MULDIV && f3[2])
					? div_res : v_q;
			end
		end
	end

	// Status to controller
	always_comb begin
		st = '0;
		st.is_push = op_q;
		st.valid_instr = valid;
		st.is_load = is_ld;
		st.is_store = is_stv;
		st.is_mul = is_mul;
		st.is_div = is_div;
		st.nbytes_m1 = nb_m1;
		st.bytes_last = bidx_q == nb_m1;
		st.div_last = dcnt_q == 6'd31;
		st.ram_hit = ram_hit;
	end

	assign res_pc = pc_q;
	assign res_exec = exec_q;
	assign res_txv = txv_q;
	assign res_txd = tx_q;
	assign res_led = led_q;
	assign res_drop = drop_q;

endmodule

@@ rtl/rv32_checker.sv @@
// Port-level checker for the RV32IM execute block, bound to the top level
module rv32_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [55:0] m_tdata,
	input logic m_tuser
);

	// Held result stays stable
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Input not taken on the edge right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted two items back to back");

	// Pad bits zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[55:51] == 5'd0)
		else $error("pad bits set");

	// A non-executed result never reports a transmit
	a_tx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> !m_tdata[32])
		else $error("tx without execution");

endmodule

bind rv32im_instruction_execute rv32_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
